FILE: design/credit_priority_scheduler_queues_assert.svh
// Assertion macros for the credit priority scheduler queues.
`ifndef CREDIT_PRIORITY_SCHEDULER_QUEUES_ASSERT_SVH
`define CREDIT_PRIORITY_SCHEDULER_QUEUES_ASSERT_SVH

`ifndef SYNTH

`define CSQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define CSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSQ_ASSERT(lbl, cond, msg)

`define CSQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/csq_pkg.sv
// Shared constants, types and codes for the credit priority scheduler queues.
`default_nettype none

package csq_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int PID_W     = 4;
  localparam int NUM_PIDS  = 1 << PID_W;
  localparam int CRED_W    = 8;
  localparam int TMR_W     = 8;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_BLOCK = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_WAIT,
    S_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    RQ_IDLE,
    RQ_LOAD,
    RQ_WALK
  } rq_state_t;

  // Request into the ready queue.
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic              use_given;
    logic [PID_W-1:0]  pid;
    logic [CRED_W-1:0] credits;
  } rdy_req_t;

  typedef struct packed {
    logic             done;
    logic [PID_W-1:0] head;
    logic [CNT_W-1:0] fill;
  } rdy_stat_t;

  // Write and fill control of the blocked queue.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [PID_W-1:0] wr_pid;
    logic [TMR_W-1:0] wr_timer;
    logic             fill_inc;
    logic             fill_load;
    logic [CNT_W-1:0] fill_val;
  } blk_ctl_t;

endpackage

`default_nettype wire

FILE: design/csq_ready_q.sv
// Ready queue: credit table, ordered list and the sequential credit compare walk.
`default_nettype none

module csq_ready_q (
  input  logic               clk,
  input  logic               rst_n,
  input  csq_pkg::rdy_req_t  req,
  output csq_pkg::rdy_stat_t stat
);
  import csq_pkg::*;

  logic [CRED_W-1:0] credit_mem [NUM_PIDS];
  logic [PID_W-1:0]  list_r [MAX_PROCS];
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  pos_r;
  logic [PID_W-1:0]  pid_r;
  logic [CRED_W-1:0] cval_r;
  rq_state_t         st_r, st_nxt;

  logic [PID_W-1:0]  rd_addr;
  logic [CRED_W-1:0] rd_cred;
  logic              walk_more;
  logic              place;
  logic              do_pop;
  logic              do_start;

  // One credit read port: the new entry's credits while loading, the walked entry otherwise.
  assign rd_addr   = (st_r == RQ_LOAD) ? pid_r : list_r[pos_r[IDX_W-1:0]];
  assign rd_cred   = credit_mem[rd_addr];
  assign walk_more = (pos_r < fill_r) && (cval_r < rd_cred);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      RQ_IDLE: begin
        if (req.ins) begin
          st_nxt = req.use_given ? RQ_WALK : RQ_LOAD;
        end
      end
      RQ_LOAD: st_nxt = RQ_WALK;
      RQ_WALK: begin
        if (!walk_more) begin
          st_nxt = RQ_IDLE;
        end
      end
      default: st_nxt = RQ_IDLE;
    endcase
  end

  always_comb begin
    place    = (st_r == RQ_WALK) && !walk_more;
    do_start = (st_r == RQ_IDLE) && req.ins;
    do_pop   = (st_r == RQ_IDLE) && req.pop && (fill_r != '0);
    stat     = '{done: place, head: list_r[0], fill: fill_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= RQ_IDLE;
      fill_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (place) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (do_pop) begin
        fill_r <= fill_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      pid_r <= req.pid;
      pos_r <= '0;
      if (req.use_given) begin
        cval_r                <= req.credits;
        credit_mem[req.pid]   <= req.credits;
      end
    end
    if (st_r == RQ_LOAD) begin
      cval_r <= rd_cred;
    end
    if ((st_r == RQ_WALK) && walk_more) begin
      pos_r <= pos_r + CNT_W'(1);
    end
    if (place) begin
      // Open a slot at the found position and move the tail back by one.
      if (pos_r == '0) begin
        list_r[0] <= pid_r;
      end
      for (int k = 1; k < MAX_PROCS; k++) begin
        if (CNT_W'(k) == pos_r) begin
          list_r[k] <= pid_r;
        end else if ((CNT_W'(k) > pos_r) && (CNT_W'(k) <= fill_r)) begin
          list_r[k] <= list_r[k-1];
        end
      end
    end else if (do_pop) begin
      for (int k = 0; k < MAX_PROCS - 1; k++) begin
        list_r[k] <= list_r[k+1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/csq_blk_q.sv
// Blocked queue: process numbers and countdown timers with one read and one write port.
`default_nettype none

module csq_blk_q (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csq_pkg::blk_ctl_t        ctl,
  input  logic [csq_pkg::IDX_W-1:0] rd_idx,
  output logic [csq_pkg::PID_W-1:0] rd_pid,
  output logic [csq_pkg::TMR_W-1:0] rd_timer,
  output logic [csq_pkg::CNT_W-1:0] fill
);
  import csq_pkg::*;

  logic [PID_W-1:0] pid_mem [MAX_PROCS];
  logic [TMR_W-1:0] tmr_mem [MAX_PROCS];
  logic [CNT_W-1:0] fill_r;

  assign rd_pid   = pid_mem[rd_idx];
  assign rd_timer = tmr_mem[rd_idx];
  assign fill     = fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.fill_load) begin
      fill_r <= ctl.fill_val;
    end else if (ctl.fill_inc) begin
      fill_r <= fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      pid_mem[ctl.wr_idx] <= ctl.wr_pid;
      tmr_mem[ctl.wr_idx] <= ctl.wr_timer;
    end
  end

endmodule

`default_nettype wire

FILE: design/credit_priority_scheduler_queues.sv
// Top level: command sequencer over the ready queue and the blocked timer queue.
`default_nettype none

// Each request runs alone: in_stall is high from acceptance until the result is
// loaded into the output register, and a new request can be taken while that
// result still waits on out_stall. Dequeue and block go from execute to done;
// an enqueue waits in between for the ready queue insert, and a tick walks the
// blocked entries, waiting for that insert for every entry that it moves. A
// finished request also waits for as long as the previous result is held by
// out_stall. The cost is set by the credit compare walk in the ready queue,
// which checks one ready entry per cycle, and by the timer unit, which
// decrements one blocked entry per cycle while no moved entry is inserted.
`include "credit_priority_scheduler_queues_assert.svh"

module credit_priority_scheduler_queues (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_pid,
  input  logic [7:0] in_credits,
  input  logic       in_tick_newest,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_pid,
  output logic       out_pid_valid,
  output logic       out_ok,
  output logic [4:0] out_returned_count,
  output logic [4:0] out_ready_count,
  output logic [4:0] out_blocked_count,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import csq_pkg::*;

  top_state_t        state_r, state_nxt;
  cmd_t              cmd_r;
  logic [PID_W-1:0]  pid_r;
  logic [CRED_W-1:0] cred_r;
  logic              upd_r;
  logic [TMR_W-1:0]  block_delay_r;
  logic [CNT_W-1:0]  i_r, w_r, lim_r, moved_r;
  logic              ok_r;
  logic [PID_W-1:0]  deq_pid_r;
  logic              deq_valid_r;
  logic              out_valid_r;

  rdy_req_t          rdy_req;
  rdy_stat_t         rdy_stat;
  blk_ctl_t          blk_ctl;
  logic [PID_W-1:0]  blk_rd_pid;
  logic [TMR_W-1:0]  blk_rd_timer;
  logic [CNT_W-1:0]  blk_fill;

  logic              accept;
  logic              out_free;
  logic              rdy_full;
  logic              blk_full;
  logic              tick_end;
  logic              dec_en;
  logic [TMR_W-1:0]  new_tmr;
  logic              expired;
  logic              move_now;
  logic              i_inc, w_inc, ok_clr, deq_cap, tick_init, out_load;

  csq_ready_q u_ready (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rdy_req),
    .stat  (rdy_stat)
  );

  csq_blk_q u_blk (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (blk_ctl),
    .rd_idx   (i_r[IDX_W-1:0]),
    .rd_pid   (blk_rd_pid),
    .rd_timer (blk_rd_timer),
    .fill     (blk_fill)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign rdy_full  = (rdy_stat.fill == CNT_W'(MAX_PROCS));
  assign blk_full  = (blk_fill == CNT_W'(MAX_PROCS));
  assign tick_end  = (i_r == blk_fill);

  // Shared timer unit: the entry under the tick pointer is decremented unless it is
  // the newest one and the tick leaves that one alone.
  assign dec_en    = (i_r < lim_r) && (blk_rd_timer != '0);
  assign new_tmr   = dec_en ? (blk_rd_timer - TMR_W'(1)) : blk_rd_timer;
  assign expired   = (new_tmr == '0);
  assign move_now  = expired && !rdy_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_ENQ:   state_nxt = rdy_full ? S_DONE : S_WAIT;
          CMD_DEQ:   state_nxt = S_DONE;
          CMD_BLOCK: state_nxt = S_DONE;
          CMD_TICK:  state_nxt = S_TICK;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_TICK: begin
        if (tick_end) begin
          state_nxt = S_DONE;
        end else if (move_now) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rdy_stat.done) begin
          state_nxt = (cmd_r == CMD_TICK) ? S_TICK : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rdy_req   = '0;
    blk_ctl   = '0;
    i_inc     = 1'b0;
    w_inc     = 1'b0;
    ok_clr    = 1'b0;
    deq_cap   = 1'b0;
    tick_init = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_EXEC: begin
        unique case (cmd_r)
          CMD_ENQ: begin
            if (rdy_full) begin
              ok_clr = 1'b1;
            end else begin
              rdy_req.ins       = 1'b1;
              rdy_req.use_given = 1'b1;
              rdy_req.pid       = pid_r;
              rdy_req.credits   = cred_r;
            end
          end
          CMD_DEQ: begin
            if (rdy_stat.fill == '0) begin
              ok_clr = 1'b1;
            end else begin
              rdy_req.pop = 1'b1;
              deq_cap     = 1'b1;
            end
          end
          CMD_BLOCK: begin
            if (blk_full) begin
              ok_clr = 1'b1;
            end else begin
              blk_ctl.wr_en    = 1'b1;
              blk_ctl.wr_idx   = blk_fill[IDX_W-1:0];
              blk_ctl.wr_pid   = pid_r;
              blk_ctl.wr_timer = (block_delay_r == '0) ? TMR_W'(1) : block_delay_r;
              blk_ctl.fill_inc = 1'b1;
            end
          end
          CMD_TICK: tick_init = 1'b1;
          default: ;
        endcase
      end
      S_TICK: begin
        if (tick_end) begin
          blk_ctl.fill_load = 1'b1;
          blk_ctl.fill_val  = w_r;
        end else if (move_now) begin
          rdy_req.ins = 1'b1;
          rdy_req.pid = blk_rd_pid;
          i_inc       = 1'b1;
        end else begin
          // Kept entry: compact it down; one that could not move retries next tick.
          blk_ctl.wr_en    = 1'b1;
          blk_ctl.wr_idx   = w_r[IDX_W-1:0];
          blk_ctl.wr_pid   = blk_rd_pid;
          blk_ctl.wr_timer = expired ? TMR_W'(1) : new_tmr;
          ok_clr           = expired;
          i_inc            = 1'b1;
          w_inc            = 1'b1;
        end
      end
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      block_delay_r <= TMR_W'(2);
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        block_delay_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= cmd_t'(in_cmd);
      pid_r       <= in_pid;
      cred_r      <= in_credits;
      upd_r       <= in_tick_newest;
      ok_r        <= 1'b1;
      deq_pid_r   <= '0;
      deq_valid_r <= 1'b0;
      moved_r     <= '0;
    end
    if (ok_clr) begin
      ok_r <= 1'b0;
    end
    if (deq_cap) begin
      deq_pid_r   <= rdy_stat.head;
      deq_valid_r <= 1'b1;
    end
    if (tick_init) begin
      i_r <= '0;
      w_r <= '0;
      if (upd_r || (blk_fill == '0)) begin
        lim_r <= blk_fill;
      end else begin
        lim_r <= blk_fill - CNT_W'(1);
      end
    end
    if (i_inc) begin
      i_r <= i_r + CNT_W'(1);
    end
    if (w_inc) begin
      w_r <= w_r + CNT_W'(1);
    end
    if (rdy_req.ins && (state_r == S_TICK)) begin
      moved_r <= moved_r + CNT_W'(1);
    end
    if (out_load) begin
      out_pid            <= deq_pid_r;
      out_pid_valid      <= deq_valid_r;
      out_ok             <= ok_r;
      out_returned_count <= moved_r;
      out_ready_count    <= rdy_stat.fill;
      out_blocked_count  <= blk_fill;
    end
  end

  assign out_valid = out_valid_r;

  `CSQ_ASSERT(a_ins_not_full, !rdy_req.ins || !rdy_full, "ready insert requested while full")
  `CSQ_ASSERT(a_compact_order, (state_r != S_TICK) || (w_r <= i_r), "tick write pointer passed read pointer")
  `CSQ_ASSERT(a_fill_bound, (rdy_stat.fill <= CNT_W'(MAX_PROCS)) && (blk_fill <= CNT_W'(MAX_PROCS)), "queue fill out of range")
  `CSQ_ASSERT_NEXT(a_result_shown, out_load, out_valid && (state_r == S_IDLE), "loaded result not presented")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the credit priority scheduler queues.
module testbench;
  import csq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 40;

  typedef struct {
    logic [3:0] pid;
    logic       pid_valid;
    logic       ok;
    logic [4:0] returned;
    logic [4:0] ready;
    logic [4:0] blocked;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd = CMD_ENQ;
  logic [3:0] in_pid = '0;
  logic [7:0] in_credits = '0;
  logic       in_tick_newest = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_pid;
  logic       out_pid_valid;
  logic       out_ok;
  logic [4:0] out_returned_count;
  logic [4:0] out_ready_count;
  logic [4:0] out_blocked_count;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  // Scheduler state as the testbench expects it.
  bit [7:0] credit_of [NUM_PIDS];
  bit       credit_known [NUM_PIDS];
  bit [3:0] ready_pids [MAX_PROCS];
  int       ready_fill;
  bit [3:0] blocked_pids [MAX_PROCS];
  bit [7:0] blocked_timer [MAX_PROCS];
  int       blocked_fill;
  bit [7:0] io_delay;

  sched_result_t pending_results[$];

  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int full_rejects = 0;
  int returned_total = 0;
  int peak_ready = 0;
  int peak_blocked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  credit_priority_scheduler_queues uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_pid             (in_pid),
    .in_credits         (in_credits),
    .in_tick_newest     (in_tick_newest),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pid            (out_pid),
    .out_pid_valid      (out_pid_valid),
    .out_ok             (out_ok),
    .out_returned_count (out_returned_count),
    .out_ready_count    (out_ready_count),
    .out_blocked_count  (out_blocked_count),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    // Keep the log readable when the design is badly broken.
    if (errors <= MAX_REPORTS)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic void reset_schedule();
    for (int i = 0; i < NUM_PIDS; i++) begin
      credit_of[i] = '0;
      credit_known[i] = 1'b0;
    end
    ready_fill = 0;
    blocked_fill = 0;
    io_delay = 8'd2;
  endfunction

  // Ordered insert: a new pid goes ahead of entries with equal credits.
  function automatic bit insert_ready(input bit [3:0] p);
    int pos;
    if (ready_fill >= MAX_PROCS) return 1'b0;
    pos = 0;
    while (pos < ready_fill && credit_of[p] < credit_of[ready_pids[pos]]) pos++;
    for (int i = ready_fill; i > pos; i--) ready_pids[i] = ready_pids[i-1];
    ready_pids[pos] = p;
    ready_fill++;
    return 1'b1;
  endfunction

  function automatic sched_result_t next_schedule_result(input cmd_t cmd, input bit [3:0] pid,
                                                         input bit [7:0] cr, input bit upd);
    sched_result_t r;
    int lim;
    int w;
    r = '{pid: '0, pid_valid: 1'b0, ok: 1'b1, returned: '0, ready: '0, blocked: '0};
    case (cmd)
      CMD_ENQ: begin
        if (ready_fill >= MAX_PROCS) begin
          r.ok = 1'b0;
        end else begin
          credit_of[pid] = cr;
          credit_known[pid] = 1'b1;
          void'(insert_ready(pid));
        end
      end
      CMD_DEQ: begin
        if (ready_fill == 0) begin
          r.ok = 1'b0;
        end else begin
          r.pid = ready_pids[0];
          r.pid_valid = 1'b1;
          for (int i = 1; i < ready_fill; i++) ready_pids[i-1] = ready_pids[i];
          ready_fill--;
        end
      end
      CMD_BLOCK: begin
        if (blocked_fill >= MAX_PROCS) begin
          r.ok = 1'b0;
        end else begin
          blocked_pids[blocked_fill] = pid;
          blocked_timer[blocked_fill] = (io_delay == 0) ? 8'd1 : io_delay;
          blocked_fill++;
        end
      end
      default: begin
        lim = blocked_fill;
        if (!upd && lim > 0) lim--;
        for (int i = 0; i < lim; i++)
          if (blocked_timer[i] > 0) blocked_timer[i]--;
        w = 0;
        for (int i = 0; i < blocked_fill; i++) begin
          if (blocked_timer[i] == 0) begin
            if (insert_ready(blocked_pids[i])) begin
              r.returned++;
              continue;
            end
            // Ready queue full: the entry stays and retries on the next tick.
            blocked_timer[i] = 8'd1;
            r.ok = 1'b0;
          end
          blocked_pids[w] = blocked_pids[i];
          blocked_timer[w] = blocked_timer[i];
          w++;
        end
        blocked_fill = w;
      end
    endcase
    r.ready = ready_fill[4:0];
    r.blocked = blocked_fill[4:0];
    return r;
  endfunction

  // Sends one request and records what it should produce once it is taken.
  task automatic send_request(input cmd_t cmd, input bit [3:0] pid, input bit [7:0] cr,
                              input bit upd);
    int gap;
    sched_result_t r;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_pid = pid;
    in_credits = cr;
    in_tick_newest = upd;
    do @(posedge clk); while (in_stall);
    r = next_schedule_result(cmd, pid, cr, upd);
    pending_results.push_back(r);
    requests_sent++;
    if (!r.ok && cmd != CMD_DEQ) full_rejects++;
    returned_total += r.returned;
    if (ready_fill > peak_ready) peak_ready = ready_fill;
    if (blocked_fill > peak_blocked) peak_blocked = blocked_fill;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_delay(input bit [7:0] v);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    io_delay = v;
  endtask

  function automatic int known_pid();
    int picks[$];
    for (int p = 0; p < NUM_PIDS; p++)
      if (credit_known[p]) picks.push_back(p);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  function automatic bit [7:0] random_credits();
    bit [7:0] tie_values [4] = '{8'h00, 8'hFF, 8'h80, 8'h3C};
    // A share of repeated values exercises the equal-credit ordering.
    if ($urandom_range(3) == 0) return tie_values[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  task automatic random_traffic(input int count);
    int we, wd, wb, pick, k;
    cmd_t cmd;
    bit [3:0] pid;
    we = 30; wd = 25; wb = 20;
    for (int n = 0; n < count; n++) begin
      // Change the command mix in bursts so the queues swing from empty to full.
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0: begin we = 30; wd = 25; wb = 20; end
          1: begin we = 55; wd = 10; wb = 25; end
          2: begin we = 10; wd = 45; wb = 5;  end
          default: begin we = 25; wd = 15; wb = 35; end
        endcase
      end
      pick = $urandom_range(99);
      if (pick < we) cmd = CMD_ENQ;
      else if (pick < we + wd) cmd = CMD_DEQ;
      else if (pick < we + wd + wb) cmd = CMD_BLOCK;
      else cmd = CMD_TICK;
      pid = 4'($urandom_range(15));
      // Only processes with stored credits may be blocked.
      if (cmd == CMD_BLOCK && !credit_known[pid]) begin
        k = known_pid();
        if (k < 0) cmd = CMD_ENQ;
        else pid = 4'(k);
      end
      send_request(cmd, pid, random_credits(), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_empty_queues();
    send_request(CMD_DEQ, 4'd15, 8'hFF, 1'b1);
    send_request(CMD_TICK, 4'd0, 8'h00, 1'b0);
    send_request(CMD_TICK, 4'd15, 8'hFF, 1'b1);
  endtask

  task automatic test_priority_order();
    send_request(CMD_ENQ, 4'd0, 8'd0, 1'b0);
    send_request(CMD_ENQ, 4'd15, 8'd255, 1'b1);
    send_request(CMD_ENQ, 4'd5, 8'd100, 1'b0);
    send_request(CMD_ENQ, 4'd9, 8'd100, 1'b0);
    send_request(CMD_ENQ, 4'd3, 8'd255, 1'b1);
    repeat (6) send_request(CMD_DEQ, 4'd0, 8'd0, 1'b0);
  endtask

  task automatic test_short_delays();
    set_delay(8'd0);
    send_request(CMD_BLOCK, 4'd15, 8'd0, 1'b0);
    send_request(CMD_TICK, 4'd0, 8'd0, 1'b1);
    set_delay(8'd1);
    send_request(CMD_BLOCK, 4'd0, 8'd0, 1'b0);
    send_request(CMD_BLOCK, 4'd9, 8'd0, 1'b0);
    // Without tick_newest the newest entry never counts down.
    send_request(CMD_TICK, 4'd0, 8'd0, 1'b0);
    send_request(CMD_TICK, 4'd0, 8'd0, 1'b0);
    send_request(CMD_TICK, 4'd0, 8'd0, 1'b1);
    repeat (4) send_request(CMD_DEQ, 4'd0, 8'd0, 1'b0);
  endtask

  task automatic test_full_queues();
    while (ready_fill > 0) send_request(CMD_DEQ, 4'd0, 8'd0, 1'b0);
    for (int p = 0; p < NUM_PIDS; p++) send_request(CMD_ENQ, 4'(p), random_credits(), 1'b0);
    send_request(CMD_ENQ, 4'd7, 8'd200, 1'b0);
    for (int p = 0; blocked_fill < MAX_PROCS; p++) send_request(CMD_BLOCK, 4'(p), 8'd0, 1'b0);
    send_request(CMD_BLOCK, 4'd2, 8'd0, 1'b0);
    send_request(CMD_TICK, 4'd0, 8'd0, 1'b1);
    repeat (20) begin
      send_request(CMD_DEQ, 4'd0, 8'd0, 1'b0);
      send_request(CMD_TICK, 4'd0, 8'd0, 1'($urandom_range(1)));
    end
    while (ready_fill > 0) send_request(CMD_DEQ, 4'd0, 8'd0, 1'b0);
    send_request(CMD_DEQ, 4'd0, 8'd0, 1'b0);
  endtask

  task automatic test_longest_delay();
    set_delay(8'd255);
    send_request(CMD_BLOCK, 4'd7, 8'd0, 1'b0);
    repeat (256) send_request(CMD_TICK, 4'd0, 8'd0, 1'b1);
    send_request(CMD_DEQ, 4'd0, 8'd0, 1'b0);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    random_traffic(30);
    while (hold_cycles > 0) @(negedge clk);
    wait_drained();
  endtask

  // Result side: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, out_pid", out_pid, 0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_pid !== want.pid) report_mismatch("out_pid", out_pid, want.pid);
        if (out_pid_valid !== want.pid_valid)
          report_mismatch("out_pid_valid", out_pid_valid, want.pid_valid);
        if (out_ok !== want.ok) report_mismatch("out_ok", out_ok, want.ok);
        if (out_returned_count !== want.returned)
          report_mismatch("out_returned_count", out_returned_count, want.returned);
        if (out_ready_count !== want.ready)
          report_mismatch("out_ready_count", out_ready_count, want.ready);
        if (out_blocked_count !== want.blocked)
          report_mismatch("out_blocked_count", out_blocked_count, want.blocked);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_schedule();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 63;
    test_empty_queues();
    test_priority_order();
    test_short_delays();
    test_full_queues();
    test_longest_delay();
    set_delay(8'd2);
    random_traffic(420);

    send_idle_pct = 63;
    recv_idle_pct = 37;
    test_backpressure();
    set_delay(8'd1);
    random_traffic(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_delay(8'd4);
    random_traffic(420);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests with %0d results checked, block delays 0, 1, 2, 4 and 255.",
             requests_sent, results_checked);
    $display("Peak ready %0d, peak blocked %0d, %0d full-queue rejects, %0d returned by ticks.",
             peak_ready, peak_blocked, full_rejects, returned_total);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
